// File: design/touch_sample_calibrate_macros.svh
// Assertion macros shared by the touch calibration RTL.
// Needs a clk and an active-high rst in the scope of use.
`ifndef TOUCH_SAMPLE_CALIBRATE_MACROS_SVH
`define TOUCH_SAMPLE_CALIBRATE_MACROS_SVH

// Same-cycle implication.
`define TSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tsc_pkg.sv
// Shared widths, register indexes, reset values and types for the touch
// calibration block. No dependencies.
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int PRESS_W  = 10;   // pressure and threshold, signed
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int RAW_W    = 11;   // decoded and averaged sample, signed
  localparam int COEF_W   = 32;
  localparam int SUM_W    = 45;   // a*x + b*y + c, magnitude below 2**43
  localparam int CLAMP_W  = 12;   // holds SCREEN_* - 1 up to 4095
  localparam int SX_W     = 9;
  localparam int SY_W     = 8;
  localparam int CFG_IDX_W = 4;
  localparam int SAMPLES  = 4;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;

  localparam logic [PRESS_W-1:0] PRESS_OFFSET = 10'd127;
  localparam logic [RAW_W-1:0]   DECODE_TOP   = 11'd1023;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_F    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR   = 4'd7;

  // Reset values.
  localparam logic signed [PRESS_W-1:0] RST_THRESHOLD = 10'sd10;
  localparam logic signed [COEF_W-1:0]  RST_ONE       = 32'sd1;
  localparam logic signed [COEF_W-1:0]  RST_ZERO      = 32'sd0;

  // Coefficients for one axis: p*x + q*y + r.
  typedef struct packed {
    logic signed [COEF_W-1:0] p;
    logic signed [COEF_W-1:0] q;
    logic signed [COEF_W-1:0] r;
  } axis_coef_t;

endpackage

// File: design/touch_sample_calibrate.sv
// Touch poll calibration: pressure test, sample averaging, affine transform.
// A touching poll runs the 22-step bit-serial multiply and the 45-step
// restoring divide; a released poll skips them. in_stall holds off a new
// poll until the last result is loaded into the output register.
// Sync reset clears control, config and held state.
`timescale 1ns / 1ps
`include "touch_sample_calibrate_macros.svh"

module touch_sample_calibrate #(
  parameter int SCREEN_WIDTH  = tsc_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tsc_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsc_pkg::COEF_W-1:0]           cfg_data,
  // poll input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tsc_pkg::BYTE_W-1:0]           z1_byte,
  input  logic [tsc_pkg::BYTE_W-1:0]           z2_byte,
  input  logic [tsc_pkg::WORD_W-1:0]           x_word_0,
  input  logic [tsc_pkg::WORD_W-1:0]           x_word_1,
  input  logic [tsc_pkg::WORD_W-1:0]           x_word_2,
  input  logic [tsc_pkg::WORD_W-1:0]           x_word_3,
  input  logic [tsc_pkg::WORD_W-1:0]           y_word_0,
  input  logic [tsc_pkg::WORD_W-1:0]           y_word_1,
  input  logic [tsc_pkg::WORD_W-1:0]           y_word_2,
  input  logic [tsc_pkg::WORD_W-1:0]           y_word_3,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tsc_pkg::PRESS_W-1:0]   pressure_value,
  output logic                                 touching,
  output logic                                 press_edge,
  output logic signed [tsc_pkg::RAW_W-1:0]     raw_x_avg,
  output logic signed [tsc_pkg::RAW_W-1:0]     raw_y_avg,
  output logic [tsc_pkg::SX_W-1:0]             screen_x,
  output logic [tsc_pkg::SY_W-1:0]             screen_y
);
  import tsc_pkg::*;

  // Poll sequencer: IDLE takes a beat, CALC waits on the x unit's done (both
  // units run in lockstep), DONE waits for room in the output register.
  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_DONE = 3'b100
  } top_state_t;

  localparam int ACC_W = RAW_W + 3;   // sum of four decoded samples

  top_state_t state, state_next;

  // configuration registers
  logic signed [PRESS_W-1:0] thr;
  logic signed [COEF_W-1:0]  coef_a, coef_b, coef_c, coef_d, coef_e, coef_f;
  logic signed [COEF_W-1:0]  coef_divisor;

  // held state
  logic                      touch_down;
  logic signed [RAW_W-1:0]   held_raw_x, held_raw_y;
  logic [SX_W-1:0]           held_screen_x;
  logic [SY_W-1:0]           held_screen_y;

  // result of the poll in flight
  logic signed [PRESS_W-1:0] res_pressure;
  logic                      res_touching;
  logic                      res_edge;
  logic                      calc_start;

  logic                      in_take;
  logic                      out_load;
  logic signed [PRESS_W-1:0] pressure_now;
  logic                      touch_now;
  logic signed [RAW_W-1:0]   avg_x_now, avg_y_now;
  axis_coef_t                cx, cy;
  logic                      ux_done, uy_done;
  logic [CLAMP_W-1:0]        ux_result, uy_result;

  // Bits 15..5 of each word decode as 1023 minus the value; the four are
  // summed and floored by an arithmetic shift of two.
  function automatic logic signed [RAW_W-1:0] decode_avg(
    input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
    input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
    logic signed [ACC_W-1:0] sum;
    sum = ACC_W'(DECODE_TOP) - ACC_W'(w0[WORD_W-1:WORD_W-RAW_W])
        + ACC_W'(DECODE_TOP) - ACC_W'(w1[WORD_W-1:WORD_W-RAW_W])
        + ACC_W'(DECODE_TOP) - ACC_W'(w2[WORD_W-1:WORD_W-RAW_W])
        + ACC_W'(DECODE_TOP) - ACC_W'(w3[WORD_W-1:WORD_W-RAW_W]);
    return sum[RAW_W+1:2];
  endfunction

  always_comb begin
    pressure_now = PRESS_W'(z1_byte) + PRESS_OFFSET - PRESS_W'(z2_byte);
    touch_now    = pressure_now > thr;
    avg_x_now    = decode_avg(x_word_0, x_word_1, x_word_2, x_word_3);
    avg_y_now    = decode_avg(y_word_0, y_word_1, y_word_2, y_word_3);
  end

  assign in_stall  = (state != T_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state == T_IDLE);
  assign out_load  = (state == T_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (in_take) state_next = touch_now ? T_CALC : T_DONE;
      T_CALC:  if (ux_done) state_next = T_DONE;
      T_DONE:  if (out_load) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Control, configuration and held state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      calc_start    <= 1'b0;
      out_valid     <= 1'b0;
      thr           <= RST_THRESHOLD;
      coef_a        <= RST_ONE;
      coef_b        <= RST_ZERO;
      coef_c        <= RST_ZERO;
      coef_d        <= RST_ZERO;
      coef_e        <= RST_ONE;
      coef_f        <= RST_ZERO;
      coef_divisor  <= RST_ONE;
      touch_down    <= 1'b0;
      held_raw_x    <= '0;
      held_raw_y    <= '0;
      held_screen_x <= '0;
      held_screen_y <= '0;
    end else begin
      state      <= state_next;
      calc_start <= in_take && touch_now;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_THRESHOLD: thr          <= cfg_data[PRESS_W-1:0];
          REG_COEF_A:    coef_a       <= cfg_data;
          REG_COEF_B:    coef_b       <= cfg_data;
          REG_COEF_C:    coef_c       <= cfg_data;
          REG_COEF_D:    coef_d       <= cfg_data;
          REG_COEF_E:    coef_e       <= cfg_data;
          REG_COEF_F:    coef_f       <= cfg_data;
          REG_DIVISOR:   coef_divisor <= cfg_data;
          default: ;     // unknown index, write dropped
        endcase
      end

      if (in_take) begin
        touch_down <= touch_now;
        if (touch_now) begin
          held_raw_x <= avg_x_now;
          held_raw_y <= avg_y_now;
        end
      end

      // both units run in lockstep, so one done serves both
      if (ux_done) begin
        held_screen_x <= ux_result[SX_W-1:0];
        held_screen_y <= uy_result[SY_W-1:0];
      end
    end
  end

  // Per-poll payload, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_pressure <= pressure_now;
      res_touching <= touch_now;
      res_edge     <= touch_now && !touch_down;
    end
    if (out_load) begin
      pressure_value <= res_pressure;
      touching       <= res_touching;
      press_edge     <= res_edge;
      raw_x_avg      <= held_raw_x;
      raw_y_avg      <= held_raw_y;
      screen_x       <= held_screen_x;
      screen_y       <= held_screen_y;
    end
  end

  assign cx = '{p: coef_a, q: coef_b, r: coef_c};
  assign cy = '{p: coef_d, q: coef_e, r: coef_f};

  tsc_axis #(.LIMIT(SCREEN_WIDTH)) u_axis_x (
    .clk     (clk),
    .rst     (rst),
    .start   (calc_start),
    .coef    (cx),
    .divisor (coef_divisor),
    .raw_x   (held_raw_x),
    .raw_y   (held_raw_y),
    .done    (ux_done),
    .result  (ux_result)
  );

  tsc_axis #(.LIMIT(SCREEN_HEIGHT)) u_axis_y (
    .clk     (clk),
    .rst     (rst),
    .start   (calc_start),
    .coef    (cy),
    .divisor (coef_divisor),
    .raw_x   (held_raw_x),
    .raw_y   (held_raw_y),
    .done    (uy_done),
    .result  (uy_result)
  );

  `TSC_ASSERT_NOW(a_units_lockstep, ux_done || uy_done, ux_done && uy_done, "axis units out of step")
  `TSC_ASSERT_NEXT(a_beat_blocks, in_take, in_stall, "second beat taken while busy")
  `TSC_ASSERT_NEXT(a_release_holds, in_take && !touch_now,
    $stable(held_screen_x) && $stable(held_screen_y), "screen moved on release")
  `TSC_ASSERT_NOW(a_edge_needs_touch, out_valid && press_edge, touching, "press edge without touch")

endmodule

// File: design/tsc_axis.sv
// One calibration axis: serial multiply-accumulate, restoring divide, clamp.
// Depends on tsc_pkg and touch_sample_calibrate_macros.svh.
`timescale 1ns / 1ps
`include "touch_sample_calibrate_macros.svh"

module tsc_axis #(
  parameter int LIMIT = tsc_pkg::DEF_SCREEN_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  tsc_pkg::axis_coef_t               coef,
  input  logic signed [tsc_pkg::COEF_W-1:0] divisor,
  input  logic signed [tsc_pkg::RAW_W-1:0]  raw_x,
  input  logic signed [tsc_pkg::RAW_W-1:0]  raw_y,
  output logic                              done,
  output logic [tsc_pkg::CLAMP_W-1:0]       result
);
  import tsc_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CLAMP_W-1:0] MAX_OUT = CLAMP_W'(LIMIT - 1);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_MACX = 6'b000010,
    A_MACY = 6'b000100,
    A_ABS  = 6'b001000,
    A_DIV  = 6'b010000,
    A_FIN  = 6'b100000
  } axis_state_t;

  axis_state_t              state, state_next;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  mcand;
  logic [RAW_W-1:0]         mplier;
  logic [CNT_W-1:0]         cnt;
  logic [SUM_W-1:0]         quo;       // dividend in, quotient out
  logic [COEF_W-1:0]        rem;
  logic [COEF_W-1:0]        dvs;
  logic                     neg;
  logic                     zero_div;

  logic signed [SUM_W-1:0]  addend;
  logic [COEF_W:0]          trial;
  logic [COEF_W+1:0]        diff;
  logic                     qbit;
  logic                     last_mac;
  logic                     last_div;

  function automatic logic signed [SUM_W-1:0] widen(input logic signed [COEF_W-1:0] v);
    return {{(SUM_W-COEF_W){v[COEF_W-1]}}, v};
  endfunction

  always_comb begin
    addend   = mplier[0] ? mcand : '0;
    trial    = {rem, quo[SUM_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvs};
    qbit     = ~diff[COEF_W+1];
    last_mac = (cnt == CNT_W'(RAW_W - 1));
    last_div = (cnt == CNT_W'(SUM_W - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE:  if (start) state_next = A_MACX;
      A_MACX:  if (last_mac) state_next = A_MACY;
      A_MACY:  if (last_mac) state_next = A_ABS;
      A_ABS:   state_next = A_DIV;
      A_DIV:   if (last_div) state_next = A_FIN;
      A_FIN:   state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == A_FIN);
    end
  end

  // Datapath, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state) inside
      A_IDLE: begin
        acc    <= widen(coef.r);
        mcand  <= widen(coef.p);
        mplier <= raw_x;
        cnt    <= '0;
      end
      A_MACX, A_MACY: begin
        // sign bit of the two's complement multiplier weighs negative
        acc <= last_mac ? acc - addend : acc + addend;
        if (last_mac) begin
          mcand  <= widen(coef.q);
          mplier <= raw_y;
          cnt    <= '0;
        end else begin
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
        end
      end
      A_ABS: begin
        quo      <= acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
        dvs      <= divisor[COEF_W-1] ? COEF_W'(-divisor) : COEF_W'(divisor);
        neg      <= acc[SUM_W-1] ^ divisor[COEF_W-1];
        zero_div <= (divisor == '0);
        rem      <= '0;
        cnt      <= '0;
      end
      A_DIV: begin
        rem <= qbit ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
        quo <= {quo[SUM_W-2:0], qbit};
        cnt <= cnt + 1'b1;
      end
      A_FIN: begin
        if (zero_div || (neg && (quo != '0))) begin
          result <= '0;
        end else if (quo > SUM_W'(LIMIT - 1)) begin
          result <= MAX_OUT;
        end else begin
          result <= quo[CLAMP_W-1:0];
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  `TSC_ASSERT_NOW(a_start_when_idle, start, state == A_IDLE, "axis started while busy")
  `TSC_ASSERT_NOW(a_result_in_range, done, result <= MAX_OUT, "axis result beyond screen")
  `TSC_ASSERT_NOW(a_zero_div_result, done && zero_div, result == '0, "zero divisor not zero")

endmodule
